>>> hdl/adc_frame_unpack_and_scale_defines.svh
// ----------------------------------------------------------------------------
// adc frame unpack and scale assertion macros
// shared property shorthands, clocked on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef ADC_FRAME_UNPACK_AND_SCALE_DEFINES_SVH
`define ADC_FRAME_UNPACK_AND_SCALE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define AFUS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("afus assertion failed");
// next-cycle implication
`define AFUS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("afus assertion failed");
`else
`define AFUS_ASSERT_NOW(lbl, ante, cons)
`define AFUS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/afus_pkg.sv
// ----------------------------------------------------------------------------
// afus_pkg
// shared constants, codes and controller/datapath link types
// ----------------------------------------------------------------------------
package afus_pkg;

   // field widths
   localparam int CH_W      = 4;
   localparam int BYTE_W    = 8;
   localparam int RAW_W     = 16;
   localparam int UV_W      = 27;
   localparam int ENABLE_W  = 15;
   localparam int ACC_W     = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 15;

   // scaling: uv = raw * 5000000 / (4095 * (acc + 1))
   localparam int SCALE_W   = 23;
   localparam int ADCMAX_W  = 12;
   localparam logic [SCALE_W-1:0]  FULL_SCALE_UV = 23'd5000000;
   localparam logic [ADCMAX_W-1:0] ADC_MAX_CODE  = 12'd4095;
   localparam int PROD_W    = RAW_W + SCALE_W;   // dividend width
   localparam int DIVISOR_W = 16;                // 4095 * 16 = 65520
   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W     = 6;

   // request kinds
   localparam logic REQ_FRAME_BYTE = 1'b0;
   localparam logic REQ_READ       = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCUMULATE_COUNT = 1'd1;

   // controller to datapath
   typedef struct packed {
      logic frame_we;    // take a frame byte
      logic read_load;   // latch raw value, sequence and divisor
      logic mul;         // form the dividend
      logic div_step;    // one restoring division step
      logic rsp_load;    // load the result registers
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;    // current step is the final one
   } sts_type;

endpackage

>>> hdl/afus_ctrl.sv
// ----------------------------------------------------------------------------
// afus_ctrl
// sequencer for the read path and owner of the handshakes
// ----------------------------------------------------------------------------
`include "adc_frame_unpack_and_scale_defines.svh"

module afus_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output afus_pkg::cmd_type cmd,
   input  afus_pkg::sts_type sts
);
   import afus_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_READ) begin
                  cmd.read_load = 1'b1;
                  state_in      = S_MUL;
               end else begin
                  cmd.frame_we = 1'b1;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a read always moves on to the multiply step
   `AFUS_ASSERT_NEXT(a_read_to_mul, req_valid && req_ready && req_type == REQ_READ, state_ff == S_MUL)
   // loading a result always raises valid
   `AFUS_ASSERT_NEXT(a_load_sets_valid, cmd.rsp_load, rsp_valid_ff)
   // the result register is never overwritten while still held
   `AFUS_ASSERT_NOW(a_no_overwrite, cmd.rsp_load, !rsp_valid_ff || rsp_ready)

endmodule

>>> hdl/afus_dp.sv
// ----------------------------------------------------------------------------
// afus_dp
// frame unpacking, channel value store, configuration and scaling datapath
// ----------------------------------------------------------------------------
`include "adc_frame_unpack_and_scale_defines.svh"

module afus_dp #(
   parameter int NUM_CHANNELS = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  afus_pkg::cmd_type                cmd,
   output afus_pkg::sts_type                sts,
   input  logic                             req_frame_start,
   input  logic [afus_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic [afus_pkg::CH_W-1:0]        req_channel,
   input  logic                             csr_we,
   input  logic [afus_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [afus_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output logic [afus_pkg::RAW_W-1:0]       rsp_raw_value,
   output logic [afus_pkg::BYTE_W-1:0]      rsp_sequence_res,
   output logic [afus_pkg::UV_W-1:0]        rsp_voltage_uv
);
   import afus_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // configuration
   logic [ENABLE_W-1:0] enable_ff;
   logic [ACC_W-1:0]    acc_ff;

   // frame state
   logic [BYTE_W-1:0]   seq_ff;
   logic [CH_W-1:0]     frame_ch_ff;
   logic                pend_ff;
   logic [BYTE_W-1:0]   latch_ff;
   logic [RAW_W-1:0]    values_ff [NUM_CHANNELS];

   // read path
   logic [RAW_W-1:0]     raw_ff;
   logic [BYTE_W-1:0]    seq_cap_ff;
   logic [DIVISOR_W-1:0] divisor_ff;
   logic [PROD_W-1:0]    quo_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [CNT_W-1:0]     cnt_ff;

   // result registers
   logic [RAW_W-1:0]     out_raw_ff;
   logic [BYTE_W-1:0]    out_seq_ff;
   logic [UV_W-1:0]      out_uv_ff;

   logic [CH_W-1:0]      next_ch;
   logic [CH_W-1:0]      wr_off;
   logic [CH_W-1:0]      rd_off;
   logic                 wr_ok;
   logic                 rd_ok;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;
   logic [ADCMAX_W+ACC_W:0] divisor_full;

   // lowest enabled channel above the current one, zero if none
   always_comb begin
      next_ch = '0;
      for (int c = NUM_CHANNELS; c >= 1; c--) begin
         if (enable_ff[c-1] && (CH_W'(c) > frame_ch_ff)) begin
            next_ch = CH_W'(c);
         end
      end
   end

   assign wr_ok  = (frame_ch_ff != '0) && (frame_ch_ff <= CH_W'(NUM_CHANNELS));
   assign wr_off = frame_ch_ff - CH_W'(1);
   assign rd_ok  = (req_channel != '0) && (req_channel <= CH_W'(NUM_CHANNELS));
   assign rd_off = req_channel - CH_W'(1);

   assign divisor_full = ADC_MAX_CODE * ({1'b0, acc_ff} + (ACC_W+1)'(1));

   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   assign sts.div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         acc_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_ENABLE:   enable_ff <= csr_wdata[ENABLE_W-1:0];
            CSR_ACCUMULATE_COUNT: acc_ff    <= csr_wdata[ACC_W-1:0];
            default: ;
         endcase
      end
   end

   // frame unpacking
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= '0;
         frame_ch_ff <= '0;
         pend_ff     <= 1'b0;
         latch_ff    <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            values_ff[i] <= '0;
         end
      end else if (cmd.frame_we) begin
         if (req_frame_start) begin
            seq_ff      <= req_data_byte;
            frame_ch_ff <= '0;
            pend_ff     <= 1'b0;
            latch_ff    <= '0;
         end else if (pend_ff) begin
            if (wr_ok) begin
               values_ff[wr_off[IDX_W-1:0]] <= {req_data_byte, latch_ff};
            end
            pend_ff <= 1'b0;
         end else if (next_ch != '0) begin
            frame_ch_ff <= next_ch;
            latch_ff    <= req_data_byte;
            pend_ff     <= 1'b1;
         end
      end
   end

   // read: capture, multiply, then restoring division one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.read_load) begin
         raw_ff     <= rd_ok ? values_ff[rd_off[IDX_W-1:0]] : '0;
         seq_cap_ff <= seq_ff;
         divisor_ff <= divisor_full[DIVISOR_W-1:0];
      end
      if (cmd.mul) begin
         quo_ff <= PROD_W'(raw_ff * FULL_SCALE_UV);
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[PROD_W-2:0], fits};
         rem_ff <= fits ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.rsp_load) begin
         out_raw_ff <= raw_ff;
         out_seq_ff <= seq_cap_ff;
         out_uv_ff  <= quo_ff[UV_W-1:0];
      end
   end

   assign rsp_raw_value    = out_raw_ff;
   assign rsp_sequence_res = out_seq_ff;
   assign rsp_voltage_uv   = out_uv_ff;

   // partial remainder stays below the divisor
   `AFUS_ASSERT_NOW(a_rem_below_div, cmd.div_step, rem_ff < divisor_ff)
   // a pending low byte always belongs to a channel
   `AFUS_ASSERT_NOW(a_pend_has_ch, pend_ff, frame_ch_ff != '0)
   // frame position never runs past the store
   `AFUS_ASSERT_NOW(a_ch_in_range, 1'b1, frame_ch_ff <= CH_W'(NUM_CHANNELS))

endmodule

>>> hdl/adc_frame_unpack_and_scale.sv
// ----------------------------------------------------------------------------
// adc_frame_unpack_and_scale
// unpacks polled adc frames into a channel store and serves scaled reads
// ----------------------------------------------------------------------------
// a frame byte is taken and gives no result; the first byte of a frame
// (req_frame_start high) is the sequence number, then one little-endian
// 16-bit word follows per enabled channel in ascending order, extra bytes are
// dropped. a read (req_type high) goes from accept to rsp_valid in steps:
// the stored value is captured at the accepting edge, then the 16x23
// multiply, the bit-serial divider by 4095*(accumulate_count+1) and the
// load of the result register; req_ready is low for that whole span.
// the result register holds while rsp_ready is low, and frame bytes are still
// taken meanwhile; a second read waits in its load step until the register
// is free. reads of channel 0 or above NUM_CHANNELS give raw 0 and 0 uv.
// configuration is a plain write port, index 0 channel_enable, index 1
// accumulate_count.
// ----------------------------------------------------------------------------

module adc_frame_unpack_and_scale #(
   parameter int NUM_CHANNELS = 15
) (
   input  logic                           clock,
   input  logic                           reset,

   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic                           req_frame_start,
   input  logic [afus_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [afus_pkg::CH_W-1:0]      req_channel,

   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [afus_pkg::RAW_W-1:0]     rsp_raw_value,
   output logic [afus_pkg::BYTE_W-1:0]    rsp_sequence_res,
   output logic [afus_pkg::UV_W-1:0]      rsp_voltage_uv,

   // configuration writes
   input  logic                           csr_we,
   input  logic [afus_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [afus_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import afus_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer and handshakes
   afus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // store, configuration and arithmetic
   afus_dp #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_frame_start  (req_frame_start),
      .req_data_byte    (req_data_byte),
      .req_channel      (req_channel),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_voltage_uv   (rsp_voltage_uv)
   );

endmodule

>>> sim/adc_frame_unpack_and_scale_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_frame_unpack_and_scale_checker
// watches the request, response and csr ports, keeps its own copy of the
// channel store and frame state, predicts every read and compares it
// ----------------------------------------------------------------------------

module adc_frame_unpack_and_scale_checker #(
   parameter int NUM_CHANNELS = 15
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_type,
   input  logic                           req_frame_start,
   input  logic [afus_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [afus_pkg::CH_W-1:0]      req_channel,

   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [afus_pkg::RAW_W-1:0]     rsp_raw_value,
   input  logic [afus_pkg::BYTE_W-1:0]    rsp_sequence_res,
   input  logic [afus_pkg::UV_W-1:0]      rsp_voltage_uv,

   input  logic                           csr_we,
   input  logic [afus_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [afus_pkg::CSR_DAT_W-1:0] csr_wdata,

   output int                             mismatch_count,
   output int                             readings_outstanding,
   output int                             readings_checked
);

   import afus_pkg::*;

   typedef struct packed {
      logic [RAW_W-1:0]  raw;
      logic [BYTE_W-1:0] seq;
      logic [UV_W-1:0]   uv;
   } reading_type;

   logic [ENABLE_W-1:0] enable_mask;
   logic [ACC_W-1:0]    acc_count;
   logic [BYTE_W-1:0]   seq_number;
   logic [RAW_W-1:0]    stored_value [1:15];
   logic [CH_W-1:0]     frame_slot;
   logic                low_pending;
   logic [BYTE_W-1:0]   low_latch;
   reading_type         expected_readings [$];
   int                  errors_seen;
   int                  reads_seen;

   function automatic logic [CH_W-1:0] next_enabled_channel(input logic [CH_W-1:0] after);
      for (int c = int'(after) + 1; c <= NUM_CHANNELS && c <= 15; c++) begin
         if (enable_mask[c-1])
            return CH_W'(c);
      end
      return '0;
   endfunction

   function automatic logic [UV_W-1:0] microvolts(input logic [RAW_W-1:0] raw,
                                                 input logic [ACC_W-1:0] acc);
      longint unsigned num;
      longint unsigned den;
      logic [UV_W-1:0] uv;
      num = 64'(raw) * 64'(FULL_SCALE_UV);
      den = 64'(ADC_MAX_CODE) * (64'(acc) + 64'd1);
      uv  = UV_W'(num / den);
      return uv;
   endfunction

   always @(posedge clock) begin
      reading_type     got;
      reading_type     want;
      logic [CH_W-1:0] nxt;
      if (reset) begin
         enable_mask = '0;
         acc_count   = '0;
         seq_number  = '0;
         for (int i = 1; i <= 15; i++)
            stored_value[i] = '0;
         frame_slot  = '0;
         low_pending = 1'b0;
         low_latch   = '0;
         expected_readings.delete();
         errors_seen = 0;
         reads_seen  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_raw_value, rsp_sequence_res, rsp_voltage_uv};
            if (expected_readings.size() == 0) begin
               $error("unexpected result: raw_value %0h sequence_res %0h voltage_uv %0d",
                      got.raw, got.seq, got.uv);
               errors_seen++;
            end else begin
               want = expected_readings.pop_front();
               reads_seen++;
               if (got.raw !== want.raw) begin
                  $error("raw_value: expected %0h, actual %0h", want.raw, got.raw);
                  errors_seen++;
               end
               if (got.seq !== want.seq) begin
                  $error("sequence_res: expected %0h, actual %0h", want.seq, got.seq);
                  errors_seen++;
               end
               if (got.uv !== want.uv) begin
                  $error("voltage_uv: expected %0d, actual %0d", want.uv, got.uv);
                  errors_seen++;
               end
            end
         end

         if (csr_we) begin
            case (csr_index)
               CSR_CHANNEL_ENABLE:   enable_mask = csr_wdata[ENABLE_W-1:0];
               CSR_ACCUMULATE_COUNT: acc_count   = csr_wdata[ACC_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            if (req_type == REQ_READ) begin
               want.seq = seq_number;
               if (req_channel >= 1 && req_channel <= NUM_CHANNELS) begin
                  want.raw = stored_value[req_channel];
                  want.uv  = microvolts(want.raw, acc_count);
               end else begin
                  want.raw = '0;
                  want.uv  = '0;
               end
               expected_readings.push_back(want);
            end else if (req_frame_start) begin
               seq_number  = req_data_byte;
               frame_slot  = '0;
               low_pending = 1'b0;
               low_latch   = '0;
            end else if (low_pending) begin
               if (frame_slot >= 1)
                  stored_value[frame_slot] = {req_data_byte, low_latch};
               low_pending = 1'b0;
            end else begin
               nxt = next_enabled_channel(frame_slot);
               if (nxt != 0) begin
                  frame_slot  = nxt;
                  low_latch   = req_data_byte;
                  low_pending = 1'b1;
               end
            end
         end
      end
      mismatch_count       <= errors_seen;
      readings_outstanding <= expected_readings.size();
      readings_checked     <= reads_seen;
   end

endmodule

>>> sim/adc_frame_unpack_and_scale_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_frame_unpack_and_scale_tb
// drives polled frames, channel reads and csr settings into the unpacker,
// with a checker beside it that predicts and compares every read result
// ----------------------------------------------------------------------------

module adc_frame_unpack_and_scale_tb;

   import afus_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // response stalls are short
   localparam int SETTLE_CYCLES  = 60;     // covers one full read in flight
   localparam int RANDOM_ITEMS   = 1300;
   localparam int PHASES         = 8;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_type;
   logic                 req_frame_start;
   logic [BYTE_W-1:0]    req_data_byte;
   logic [CH_W-1:0]      req_channel;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [RAW_W-1:0]     rsp_raw_value;
   logic [BYTE_W-1:0]    rsp_sequence_res;
   logic [UV_W-1:0]      rsp_voltage_uv;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   int mismatch_count;
   int readings_outstanding;
   int readings_checked;

   // stimulus bookkeeping
   int                  send_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   int                  items_sent    = 0;
   int                  phase_items   = 0;
   int                  configs_used  = 0;
   int                  quiet_cycles  = 0;
   logic [ENABLE_W-1:0] current_enable = '0;

   adc_frame_unpack_and_scale DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_frame_start  (req_frame_start),
      .req_data_byte    (req_data_byte),
      .req_channel      (req_channel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_voltage_uv   (rsp_voltage_uv),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   adc_frame_unpack_and_scale_checker reading_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_frame_start      (req_frame_start),
      .req_data_byte        (req_data_byte),
      .req_channel          (req_channel),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_raw_value        (rsp_raw_value),
      .rsp_sequence_res     (rsp_sequence_res),
      .rsp_voltage_uv       (rsp_voltage_uv),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .readings_outstanding (readings_outstanding),
      .readings_checked     (readings_checked)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver side: random back-pressure, none when the stall rate is zero
   always @(posedge clock) begin
      rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog: counts cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // one item on the request channel; returns at the edge that accepts it,
   // with valid still high so a following item can go out back to back
   task automatic send_item(input logic kind, input logic start,
                            input logic [BYTE_W-1:0] data, input logic [CH_W-1:0] ch);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_frame_start <= start;
      req_data_byte   <= data;
      req_channel     <= ch;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
      phase_items++;
   endtask

   // frame byte; the channel field is don't-care and gets random bits
   task automatic send_byte(input logic start, input logic [BYTE_W-1:0] data);
      send_item(REQ_FRAME_BYTE, start, data, CH_W'($urandom));
   endtask

   // channel read; the frame fields are don't-care and get random bits
   task automatic send_read(input logic [CH_W-1:0] ch);
      send_item(REQ_READ, 1'($urandom), BYTE_W'($urandom), ch);
   endtask

   // mostly valid channels, sometimes channel 0
   task automatic send_random_read();
      if ($urandom_range(9) == 0)
         send_read('0);
      else
         send_read(CH_W'($urandom_range(15, 1)));
   endtask

   // drain, let the block go quiet, then write both registers
   task automatic configure(input logic [ENABLE_W-1:0] enable, input logic [CSR_DAT_W-1:0] acc_word);
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_CHANNEL_ENABLE;
      csr_wdata <= CSR_DAT_W'(enable);
      @(posedge clock);
      csr_index <= CSR_ACCUMULATE_COUNT;
      csr_wdata <= acc_word;
      @(posedge clock);
      csr_we <= 1'b0;
      current_enable = enable;
      configs_used++;
   endtask

   // sequence byte plus one word per enabled channel; a broken frame is cut
   // short or runs long, and reads may land between bytes
   task automatic send_frame(input bit broken);
      int n_bytes;
      n_bytes = 2 * $countones(current_enable);
      if (broken) begin
         if ($urandom_range(1) == 0)
            n_bytes = $urandom_range(n_bytes);
         else
            n_bytes = n_bytes + $urandom_range(4, 1);
      end
      send_byte(1'b1, BYTE_W'($urandom));
      for (int i = 0; i < n_bytes; i++) begin
         if ($urandom_range(19) == 0)
            send_random_read();
         send_byte(1'b0, BYTE_W'($urandom));
      end
   endtask

   initial begin
      int r;
      logic [ENABLE_W-1:0] mask;
      logic [ACC_W-1:0]    acc;

      // every input known from time zero
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_type        <= REQ_FRAME_BYTE;
      req_frame_start <= 1'b0;
      req_data_byte   <= '0;
      req_channel     <= '0;
      rsp_ready       <= 1'b0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_CHANNEL_ENABLE;
      csr_wdata       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---------------- directed part ----------------
      configure(15'h7FFF, 15'd0);
      // bytes before any frame start fill channel 1 as if a frame had begun
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, 8'hFF);
      send_read(4'd1);        // full-scale raw value at the smallest divisor
      send_read(4'd0);        // invalid channel
      send_read(4'd15);       // never written since reset
      // frame start in mid-word drops the pending low byte
      send_byte(1'b1, 8'hFF);
      send_byte(1'b0, 8'h00);
      send_byte(1'b1, 8'h00);
      send_byte(1'b0, 8'h34);
      send_byte(1'b0, 8'h12);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, 8'h80);
      send_read(4'd1);
      send_read(4'd2);
      send_read(4'd3);
      // mask changed mid-frame: the search resumes under the new mask
      configure(15'h4000, 15'h000F);
      send_byte(1'b0, 8'hAB);
      send_byte(1'b0, 8'hCD);
      // past the last enabled channel, ignored
      send_byte(1'b0, 8'h11);
      send_byte(1'b0, 8'h22);
      send_read(4'd15);       // largest divisor
      send_read(4'd3);

      // ---------------- random part ----------------
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 50; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 50; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         case (phase)
            0: begin mask = 15'h7FFF; acc = 4'd0;  end
            1: begin mask = 15'h0000; acc = 4'd15; end
            2: begin mask = 15'h7FFF; acc = 4'd15; end
            3: begin mask = 15'h0001; acc = 4'd0;  end
            default: begin
               mask = ENABLE_W'($urandom);
               acc  = ACC_W'($urandom);
            end
         endcase
         // upper csr bits are junk for the 4-bit register in later phases
         if (phase >= 4)
            configure(mask, {11'($urandom), acc});
         else
            configure(mask, CSR_DAT_W'(acc));

         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / PHASES) begin
            r = $urandom_range(99);
            if (r < 65) begin
               // well-formed frames mostly, some cut short or overlong
               send_frame($urandom_range(4) == 0);
               repeat ($urandom_range(3, 1)) send_random_read();
            end else if (r < 80) begin
               repeat ($urandom_range(3, 1)) send_random_read();
            end else begin
               // noise: fully random items
               repeat ($urandom_range(6, 1))
                  send_item(1'($urandom), 1'($urandom), BYTE_W'($urandom), CH_W'($urandom));
            end
         end
      end

      // drain and let the last read finish
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d request items driven, %0d reads predicted and compared",
               items_sent, readings_checked);
      $display("%0d mask and accumulate settings under mixed sender gaps and response stalls",
               configs_used);
      if (mismatch_count == 0 && readings_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
